@@ hw/rtl/uart_bit_bang_transmitter_core_macros.svh @@
`ifndef UART_BIT_BANG_TRANSMITTER_CORE_MACROS_SVH
`define UART_BIT_BANG_TRANSMITTER_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define UBBT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UBBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ubbt_pkg.sv @@
package ubbt_pkg;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic tx_line;
        logic done_res;
    } t_out;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_DATA = 3'b010,
        PH_STOP = 3'b100
    } t_phase;

    localparam logic        FUNC_TICK       = 1'b0;
    localparam logic        FUNC_SEND       = 1'b1;
    localparam logic [3:0]  DATA_BITS       = 4'd8;
    localparam logic [15:0] TICK_MAX        = 16'hFFFF;
    localparam logic [7:0]  BIT_TICKS_RST   = 8'd20;
    localparam logic [15:0] FRAME_TICKS_RST = 16'd220;

    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TICKS = 1'b1;

endpackage

@@ hw/rtl/ubbt_in_stage.sv @@
module ubbt_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ubbt_pkg::t_in i_data,
    input  logic          i_take,
    output logic          o_ready,
    output logic          o_valid,
    output ubbt_pkg::t_in o_data
);

    logic          r_valid;
    ubbt_pkg::t_in r_data;
    logic          w_load;

    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hw/rtl/ubbt_frame.sv @@
module ubbt_frame (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  ubbt_pkg::t_in  i_item,
    input  logic [7:0]     i_bit_ticks,
    input  logic [15:0]    i_frame_ticks,
    output ubbt_pkg::t_out o_res
);

    logic [7:0]       r_shift, n_shift;
    logic [3:0]       r_bits,  n_bits;
    logic [15:0]      r_tick,  n_tick;
    ubbt_pkg::t_phase r_phase, n_phase;
    logic             r_line,  n_line;
    logic             r_done,  n_done;

    logic        w_busy;
    logic [4:0]  w_bits_inc;
    logic [12:0] w_bound;
    logic        w_bnd;
    logic        w_stop;

    assign w_busy     = (r_phase == ubbt_pkg::PH_DATA) || (r_phase == ubbt_pkg::PH_STOP);
    assign w_bits_inc = {1'b0, r_bits} + 5'd1;
    assign w_bound    = 13'(i_bit_ticks) * 13'(w_bits_inc);

    always_comb begin
        n_shift = r_shift;
        n_bits  = r_bits;
        n_tick  = r_tick;
        n_phase = r_phase;
        n_line  = r_line;
        n_done  = r_done;
        w_bnd   = 1'b0;
        w_stop  = 1'b0;
        case (i_item.func)
            ubbt_pkg::FUNC_SEND: begin
                if (!w_busy) begin
                    n_shift = i_item.data_byte;
                    n_bits  = '0;
                    n_tick  = '0;
                    n_done  = 1'b0;
                    n_line  = 1'b0;
                    n_phase = ubbt_pkg::PH_DATA;
                end
            end
            ubbt_pkg::FUNC_TICK: begin
                if (w_busy) begin
                    if (r_tick != ubbt_pkg::TICK_MAX) begin
                        n_tick = r_tick + 16'd1;
                    end
                    w_bnd = (r_phase == ubbt_pkg::PH_DATA) && (n_tick >= {3'b000, w_bound});
                    if (w_bnd) begin
                        if (r_bits < ubbt_pkg::DATA_BITS) begin
                            n_line  = r_shift[0];
                            n_shift = {1'b0, r_shift[7:1]};
                            n_bits  = r_bits + 4'd1;
                        end else begin
                            n_line  = 1'b1;
                            n_bits  = '0;
                            n_phase = ubbt_pkg::PH_STOP;
                        end
                    end
                    w_stop = (n_phase == ubbt_pkg::PH_STOP) && (n_tick >= i_frame_ticks);
                    if (w_stop) begin
                        n_done  = 1'b1;
                        n_phase = ubbt_pkg::PH_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_bits  <= '0;
            r_tick  <= '0;
            r_phase <= ubbt_pkg::PH_IDLE;
            r_line  <= 1'b1;
            r_done  <= 1'b1;
        end else if (i_fire) begin
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_tick  <= n_tick;
            r_phase <= n_phase;
            r_line  <= n_line;
            r_done  <= n_done;
        end
    end

    assign o_res.tx_line  = n_line;
    assign o_res.done_res = n_done;

endmodule

@@ hw/rtl/uart_bit_bang_transmitter_core.sv @@
// An input beat is registered in the input stage, and its result in the result register.
// Throughput: one item per cycle while the output is not stalled; the frame update is
// combinational between the input register and the result register and holds one 8x5
// multiply. Reset (synchronous, active low): line high, done set, no frame in progress,
// bit_ticks = 20, frame_ticks = 220, both channels empty.
module uart_bit_bang_transmitter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ubbt_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ubbt_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ubbt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ubbt_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    logic           w_item_valid;
    ubbt_pkg::t_in  w_item;
    logic           w_fire;
    ubbt_pkg::t_out w_res;

    logic           r_out_valid;
    ubbt_pkg::t_out r_out;
    logic [7:0]     r_bit_ticks;
    logic [15:0]    r_frame_ticks;

    assign w_fire = w_item_valid && (!r_out_valid || i_out_ready);

    ubbt_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_take  (w_fire),
        .o_ready (o_in_ready),
        .o_valid (w_item_valid),
        .o_data  (w_item)
    );

    ubbt_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_item        (w_item),
        .i_bit_ticks   (r_bit_ticks),
        .i_frame_ticks (r_frame_ticks),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks   <= ubbt_pkg::BIT_TICKS_RST;
            r_frame_ticks <= ubbt_pkg::FRAME_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ubbt_pkg::CFG_BIT_TICKS:   r_bit_ticks   <= i_cfg_data[7:0];
                ubbt_pkg::CFG_FRAME_TICKS: r_frame_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hw/rtl/ubbt_checker.sv @@
`include "uart_bit_bang_transmitter_core_macros.svh"

module ubbt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input ubbt_pkg::t_out                 o_out_data
);

    `UBBT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result beat dropped")
    `UBBT_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_data), "beat moved")
    `UBBT_ASSERT_NOW(a_in_free, !o_out_valid, o_in_ready, "input stalled with empty output")
    `UBBT_ASSERT_NOW(a_low_busy, o_out_valid && !o_out_data.tx_line, !o_out_data.done_res, "done with line low")

endmodule

bind uart_bit_bang_transmitter_core ubbt_checker u_ubbt_checker (.*);

@@ tb/uart_bit_bang_transmitter_core_test.sv @@
module uart_bit_bang_transmitter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    ubbt_pkg::t_in                  in_data   = '0;
    logic                           out_ready = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [ubbt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ubbt_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

    logic                           o_in_ready;
    logic                           o_out_valid;
    ubbt_pkg::t_out                 o_out_data;
    logic                           o_cfg_ready;

    ubbt_pkg::t_in                  tx_requests[$];
    ubbt_pkg::t_out                 line_forecast[$];
    int unsigned                    line_errors    = 0;
    int unsigned                    send_gap_pct   = 22;
    int unsigned                    recv_stall_pct = 46;

    logic [7:0]                     bit_ticks_cfg;
    logic [15:0]                    frame_ticks_cfg;
    logic [7:0]                     shift_q;
    logic [3:0]                     sent_q;
    logic [15:0]                    ticks_q;
    ubbt_pkg::t_phase               phase_q;
    logic                           line_q;
    logic                           done_q;

    uart_bit_bang_transmitter_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic ubbt_pkg::t_out advance_line(ubbt_pkg::t_in beat);
        int unsigned    boundary;
        ubbt_pkg::t_out res;
        if (beat.func == ubbt_pkg::FUNC_SEND) begin
            if (phase_q != ubbt_pkg::PH_DATA && phase_q != ubbt_pkg::PH_STOP) begin
                shift_q = beat.data_byte;
                sent_q  = '0;
                ticks_q = '0;
                done_q  = 1'b0;
                line_q  = 1'b0;
                phase_q = ubbt_pkg::PH_DATA;
            end
        end else if (phase_q == ubbt_pkg::PH_DATA || phase_q == ubbt_pkg::PH_STOP) begin
            if (ticks_q != ubbt_pkg::TICK_MAX)
                ticks_q++;
            boundary = int'(bit_ticks_cfg) * (int'(sent_q) + 1);
            if (phase_q == ubbt_pkg::PH_DATA && int'(ticks_q) >= boundary) begin
                if (sent_q < ubbt_pkg::DATA_BITS) begin
                    line_q  = shift_q[0];
                    shift_q = shift_q >> 1;
                    sent_q++;
                end else begin
                    line_q  = 1'b1;
                    sent_q  = '0;
                    phase_q = ubbt_pkg::PH_STOP;
                end
            end
            if (phase_q == ubbt_pkg::PH_STOP && ticks_q >= frame_ticks_cfg) begin
                done_q  = 1'b1;
                phase_q = ubbt_pkg::PH_IDLE;
            end
        end
        res.tx_line  = line_q;
        res.done_res = done_q;
        return res;
    endfunction

    function automatic void push_beat(logic func, logic [7:0] data_byte);
        ubbt_pkg::t_in beat;
        beat.func      = func;
        beat.data_byte = data_byte;
        tx_requests.push_back(beat);
    endfunction

    function automatic void push_ticks(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            push_beat(ubbt_pkg::FUNC_TICK, 8'($urandom));
    endfunction

    task automatic wait_drained();
        do @(negedge clk);
        while (tx_requests.size() != 0 || in_valid || line_forecast.size() != 0);
    endtask

    task automatic write_reg(logic [ubbt_pkg::CFG_IDX_W-1:0] idx,
                             logic [ubbt_pkg::CFG_DAT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!o_cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == ubbt_pkg::CFG_BIT_TICKS)
            bit_ticks_cfg = value[7:0];
        else
            frame_ticks_cfg = value;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                line_forecast.push_back(advance_line(in_data));
            if (!in_valid || o_in_ready) begin
                if (tx_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= tx_requests.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        ubbt_pkg::t_out want;
        if (rst_n && o_out_valid && out_ready) begin
            if (line_forecast.size() == 0) begin
                $error("result beat with none pending: tx_line=%0b done_res=%0b",
                       o_out_data.tx_line, o_out_data.done_res);
                line_errors++;
            end else begin
                want = line_forecast.pop_front();
                if (o_out_data.tx_line !== want.tx_line) begin
                    $error("tx_line: expected %0b, actual %0b",
                           want.tx_line, o_out_data.tx_line);
                    line_errors++;
                end
                if (o_out_data.done_res !== want.done_res) begin
                    $error("done_res: expected %0b, actual %0b",
                           want.done_res, o_out_data.done_res);
                    line_errors++;
                end
            end
        end
    end

    initial begin
        int unsigned random_items;
        int unsigned phase_items;
        int unsigned bt;
        int unsigned ft;
        int unsigned stop_at;
        int unsigned need;
        int unsigned tail;
        int unsigned busy_at;
        int unsigned k;
        logic [7:0]  byte_v;

        bit_ticks_cfg   = ubbt_pkg::BIT_TICKS_RST;
        frame_ticks_cfg = ubbt_pkg::FRAME_TICKS_RST;
        shift_q         = '0;
        sent_q          = '0;
        ticks_q         = '0;
        phase_q         = ubbt_pkg::PH_IDLE;
        line_q          = 1'b1;
        done_q          = 1'b1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // tick while idle, then a send while busy at reset timing
        push_ticks(1);
        push_beat(ubbt_pkg::FUNC_SEND, 8'h00);
        push_ticks(1);
        push_beat(ubbt_pkg::FUNC_SEND, 8'hFF);
        push_ticks(2);
        wait_drained();

        // zero bit period with the shortest frame: stop and done on one tick
        write_reg(ubbt_pkg::CFG_BIT_TICKS, '0);
        write_reg(ubbt_pkg::CFG_FRAME_TICKS, 16'd1);
        push_ticks(9);
        push_beat(ubbt_pkg::FUNC_SEND, 8'hFF);
        push_ticks(10);
        wait_drained();

        random_items = 0;
        while (random_items < 690) begin
            if (random_items < 230) begin
                send_gap_pct   = 22;
                recv_stall_pct = 46;
            end else if (random_items < 460) begin
                send_gap_pct   = 46;
                recv_stall_pct = 22;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            bt      = ($urandom_range(9) < 2) ? $urandom_range(12, 5) : $urandom_range(3, 1);
            stop_at = 9 * bt;
            ft      = $urandom_range(1) ? $urandom_range(stop_at, 1)
                                        : stop_at + $urandom_range(20);
            write_reg(ubbt_pkg::CFG_BIT_TICKS, ubbt_pkg::CFG_DAT_W'(bt));
            write_reg(ubbt_pkg::CFG_FRAME_TICKS, ubbt_pkg::CFG_DAT_W'(ft));

            phase_items = 0;
            while (phase_items < 80) begin
                if ($urandom_range(99) < 80) begin
                    need    = (stop_at > ft) ? stop_at : ft;
                    tail    = $urandom_range(2);
                    busy_at = ($urandom_range(9) == 0) ? $urandom_range(need - 1) : need + 10;
                    if ($urandom_range(9) == 0)
                        byte_v = $urandom_range(1) ? 8'hFF : 8'h00;
                    else
                        byte_v = 8'($urandom);
                    push_beat(ubbt_pkg::FUNC_SEND, byte_v);
                    for (int unsigned i = 0; i < need + tail; i++) begin
                        if (i == busy_at)
                            push_beat(ubbt_pkg::FUNC_SEND, 8'($urandom));
                        push_ticks(1);
                    end
                    phase_items += 1 + need;
                end else begin
                    k = $urandom_range(6, 1);
                    repeat (k) push_beat(1'($urandom_range(1)), 8'($urandom));
                    phase_items += k;
                end
            end
            random_items += phase_items;
            wait_drained();
        end

        // longest bit period and longest frame: start bit into the first data bit
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_reg(ubbt_pkg::CFG_BIT_TICKS, ubbt_pkg::CFG_DAT_W'(8'd255));
        write_reg(ubbt_pkg::CFG_FRAME_TICKS, ubbt_pkg::TICK_MAX);
        push_beat(ubbt_pkg::FUNC_SEND, 8'hC3);
        push_ticks(260);
        wait_drained();

        repeat (4) @(posedge clk);
        if (line_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
